// ----- hdl/tfp_pkg.sv -----
// shared types and constants for the temperature frame parser
// used by every module of the block; no dependencies
package tfp_pkg;

  localparam int MAX_FRAME_LEN = 200;
  localparam int POS_W = $clog2(MAX_FRAME_LEN + 1);
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] BYTE_STX = 8'h02;
  localparam logic [7:0] BYTE_ETX = 8'h03;
  localparam logic [7:0] ASCII_ZERO = 8'h30;

  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_FRAME_LEN);
  localparam logic [POS_W-1:0] LAST_OK_POS = POS_W'(MAX_FRAME_LEN - 2);
  localparam logic [POS_W-1:0] FIRST_OK_POS = POS_W'(23 - 1);
  localparam logic [POS_W-1:0] HEX_FIRST = POS_W'(19);
  localparam logic [POS_W-1:0] HEX_LAST = POS_W'(22);

  localparam logic [1:0] CFG_UPPER = 2'd0;
  localparam logic [1:0] CFG_LOWER = 2'd1;
  localparam logic [1:0] CFG_LIMIT = 2'd2;

  localparam logic [1:0] ST_IN_BAND = 2'd0;
  localparam logic [1:0] ST_OUT_BAND = 2'd1;
  localparam logic [1:0] ST_SPIKE = 2'd2;
  localparam logic [1:0] ST_REJECT = 2'd3;

  typedef struct packed {
    logic        ok;
    logic [15:0] value;
  } desc_t;

  typedef struct packed {
    logic [15:0] upper_bound;
    logic [15:0] lower_bound;
    logic [7:0]  spike_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  frame_status;
    logic [15:0] raw_value;
    logic [15:0] held_value;
  } result_t;

endpackage

// ----- hdl/tfp_front.sv -----
// front end: frame parser, one byte a beat, emits a frame descriptor at each etx
// depends on tfp_pkg
module tfp_front import tfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output logic       desc_valid,
  output desc_t      desc
);

  typedef struct packed {
    logic       valid;
    logic [3:0] nibble;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.valid = 1'b1;
    h.nibble = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.nibble = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.nibble = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.nibble = 4'(c - 8'h37);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic             starts_with_stx, starts_with_stx_next;
  logic             codes_ok, codes_ok_next;
  logic [15:0]      hex_accumulator, hex_accumulator_next;
  logic             hex_stopped, hex_stopped_next;

  logic             is_stx, is_etx, code_pos, len_ok;
  logic [POS_W-1:0] pos;
  hex_t             hex;

  always_comb begin
    is_stx = rx_byte == BYTE_STX;
    is_etx = rx_byte == BYTE_ETX;
    pos = is_stx ? '0 : byte_position;
    starts_with_stx_next = is_stx ? 1'b0 : starts_with_stx;
    if (pos == '0) begin
      starts_with_stx_next = is_stx;
    end
    code_pos = pos == POS_W'(5) || pos == POS_W'(6) ||
               (pos >= POS_W'(11) && pos <= POS_W'(14));
    codes_ok_next = is_stx ? 1'b1 : codes_ok;
    if (code_pos && rx_byte != ASCII_ZERO) begin
      codes_ok_next = 1'b0;
    end
    hex_accumulator_next = is_stx ? 16'd0 : hex_accumulator;
    hex_stopped_next = is_stx ? 1'b0 : hex_stopped;
    hex = hex_digit(rx_byte);
    if (pos >= HEX_FIRST && pos <= HEX_LAST && !hex_stopped_next) begin
      if (hex.valid) begin
        hex_accumulator_next = {hex_accumulator_next[11:0], hex.nibble};
      end else begin
        hex_stopped_next = 1'b1;
      end
    end
    byte_position_next = (pos < MAX_POS) ? pos + POS_W'(1) : pos;
    len_ok = pos >= FIRST_OK_POS && pos <= LAST_OK_POS;
    desc.ok = len_ok && starts_with_stx_next && codes_ok_next;
    desc.value = desc.ok ? hex_accumulator_next : 16'd0;
    desc_valid = accept && is_etx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      starts_with_stx <= 1'b0;
      codes_ok <= 1'b1;
      hex_accumulator <= 16'd0;
      hex_stopped <= 1'b0;
    end else if (accept) begin
      if (is_etx) begin
        byte_position <= '0;
        starts_with_stx <= 1'b0;
        codes_ok <= 1'b1;
        hex_accumulator <= 16'd0;
        hex_stopped <= 1'b0;
      end else begin
        byte_position <= byte_position_next;
        starts_with_stx <= starts_with_stx_next;
        codes_ok <= codes_ok_next;
        hex_accumulator <= hex_accumulator_next;
        hex_stopped <= hex_stopped_next;
      end
    end
  end

endmodule

// ----- hdl/tfp_queue.sv -----
// short descriptor queue between the parser and the spike filter
// depends on tfp_pkg
module tfp_queue import tfp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  desc_t wr_data,
  output logic  full,
  input  logic  rd_en,
  output logic  rd_valid,
  output desc_t rd_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  desc_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign full = count == CNT_W'(QUEUE_DEPTH);
  assign rd_valid = count != '0;
  assign rd_data = slots[rd_ptr];
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- hdl/tfp_back.sv -----
// back end: spike filter with persistence counters and the result register
// depends on tfp_pkg
module tfp_back import tfp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    q_valid,
  input  desc_t   q_desc,
  output logic    q_take,
  input  logic    pop,
  output logic    out_valid,
  output result_t result
);

  logic [7:0]  upper_spike_count, upper_spike_count_next;
  logic [7:0]  lower_spike_count, lower_spike_count_next;
  logic [15:0] stored_value, stored_value_next;
  result_t     result_next;

  assign q_take = q_valid && (!out_valid || pop);

  always_comb begin
    upper_spike_count_next = upper_spike_count;
    lower_spike_count_next = lower_spike_count;
    stored_value_next = stored_value;
    result_next.raw_value = q_desc.value;
    if (!q_desc.ok) begin
      result_next.frame_status = ST_REJECT;
      result_next.raw_value = 16'd0;
    end else if (q_desc.value >= cfg.upper_bound) begin
      if (upper_spike_count > cfg.spike_limit) begin
        stored_value_next = q_desc.value;
        result_next.frame_status = ST_OUT_BAND;
      end else begin
        if (upper_spike_count != 8'hff) begin
          upper_spike_count_next = upper_spike_count + 8'd1;
        end
        result_next.frame_status = ST_SPIKE;
      end
    end else if (q_desc.value < cfg.lower_bound) begin
      if (lower_spike_count > cfg.spike_limit) begin
        stored_value_next = q_desc.value;
        result_next.frame_status = ST_OUT_BAND;
      end else begin
        if (lower_spike_count != 8'hff) begin
          lower_spike_count_next = lower_spike_count + 8'd1;
        end
        result_next.frame_status = ST_SPIKE;
      end
    end else begin
      stored_value_next = q_desc.value;
      upper_spike_count_next = 8'd0;
      lower_spike_count_next = 8'd0;
      result_next.frame_status = ST_IN_BAND;
    end
    result_next.held_value = stored_value_next;
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_spike_count <= 8'd0;
      lower_spike_count <= 8'd0;
      stored_value <= 16'd0;
      out_valid <= 1'b0;
    end else begin
      if (q_take) begin
        upper_spike_count <= upper_spike_count_next;
        lower_spike_count <= lower_spike_count_next;
        stored_value <= stored_value_next;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/temp_frame_parser_spike_filter.sv -----
// top level of the temperature frame parser with spike filter
// depends on tfp_pkg, tfp_front, tfp_queue, tfp_back
//
// Bytes are taken one a cycle whenever push is high and full is low; a byte that is not
// etx gives no result. Each etx yields one result: the parser classifies the frame in the
// cycle the etx is taken, the descriptor is written into a four-entry queue, and the spike
// filter then takes it from the queue and updates its counters and the result register
// together.
// Sustained rate is one byte per cycle while results are popped; full rises only when
// four frame descriptors are queued behind an unpopped result. Configuration writes
// take effect at once and are meant for an idle block.
module temp_frame_parser_spike_filter import tfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  frame_status,
  output logic [15:0] raw_value,
  output logic [15:0] held_value,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg;
  desc_t   front_desc, q_desc;
  logic    front_valid, q_valid, q_take, out_valid, accept;
  result_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.upper_bound <= 16'd10;
      cfg.lower_bound <= 16'd40;
      cfg.spike_limit <= 8'd3;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_UPPER: cfg.upper_bound <= cfg_data;
        CFG_LOWER: cfg.lower_bound <= cfg_data;
        CFG_LIMIT: cfg.spike_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  tfp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .rx_byte    (rx_byte),
    .desc_valid (front_valid),
    .desc       (front_desc)
  );

  tfp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (front_valid),
    .wr_data  (front_desc),
    .full     (full),
    .rd_en    (q_take),
    .rd_valid (q_valid),
    .rd_data  (q_desc)
  );

  tfp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_desc    (q_desc),
    .q_take    (q_take),
    .pop       (pop),
    .out_valid (out_valid),
    .result    (result)
  );

  assign empty = !out_valid;
  assign frame_status = result.frame_status;
  assign raw_value = result.raw_value;
  assign held_value = result.held_value;

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_status == ST_REJECT) |-> raw_value == 16'd0)
    else $error("rejected frame with nonzero value");

  a_accept_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && (frame_status == ST_IN_BAND || frame_status == ST_OUT_BAND))
      |-> held_value == raw_value)
    else $error("accepted value not stored");

endmodule
